FILE: hdl/luhn_pkg.sv
// Package for the Luhn card number classifier.
// Holds widths, the card kind codes and the structs shared by the cells,
// the accumulator and the top level. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package luhn_pkg;

  // Input width and digit capacity of the BCD chain
  localparam int IN_W       = 63;
  localparam int MAX_DIGITS = 19;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(IN_W);

  // Result field widths
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 5;
  localparam int TOTAL_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INVALID    = 2'd0,
    KIND_VISA       = 2'd1,
    KIND_MASTERCARD = 2'd2,
    KIND_AMEX       = 2'd3
  } card_kind_e;

  // Control for every digit cell in the chain
  typedef struct packed {
    logic clear;
    logic convert;
    logic drain;
  } cell_ctrl_t;

  // Control for the digit accumulator
  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

  // One finished result item
  typedef struct packed {
    card_kind_e               kind;
    logic                     ok;
    logic [COUNT_W-1:0]       count;
    logic [TOTAL_W-1:0]       total;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/luhn_if.sv
// Channel interfaces of the Luhn card number classifier.
// luhn_in_if carries card numbers, luhn_out_if carries result items.
// Depends on luhn_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface luhn_in_if
  import luhn_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] card_value;

  modport source (output valid, output card_value, input ready);
  modport sink   (input valid, input card_value, output ready);
endinterface

interface luhn_out_if
  import luhn_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  card_kind;
  logic               checksum_ok;
  logic [COUNT_W-1:0] digit_count;
  logic [TOTAL_W-1:0] luhn_total;

  modport source (output valid, output card_kind, output checksum_ok,
                  output digit_count, output luhn_total, input ready);
  modport sink   (input valid, input card_kind, input checksum_ok,
                  input digit_count, input luhn_total, output ready);
endinterface

`default_nettype wire

FILE: hdl/luhn_digit_cell.sv
// One BCD digit cell of the binary-to-decimal chain.
// Converts by add-3 and shift, then drains its digit toward cell zero.
// Depends on luhn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module luhn_digit_cell
  import luhn_pkg::*;
(
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       bit_i,
  input  wire logic [3:0] digit_i,
  output logic            bit_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // Correct the digit before it doubles
  assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o = adj[3];

  // Select next digit: clear, shift one bit in, or take the upper digit
  always_comb begin
    digit_d = digit_q;
    priority if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.convert) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.drain) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

FILE: hdl/luhn_accum.sv
// Digit accumulator: Luhn total, digit count and leading digits.
// Takes one digit per cycle while step is set, from the bottom of the cell chain, and
// classifies the card. Depends on luhn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module luhn_accum
  import luhn_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire acc_ctrl_t            ctrl_i,
  input  wire logic [3:0]           digit_i,
  input  wire logic [DIG_IDX_W-1:0] idx_i,
  output result_t                   result_o
);

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [3:0]         mod_q, mod_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [3:0]         d12_q, d13_q, d14_q, d15_q;
  logic [4:0]         dbl;
  logic [3:0]         weighted;
  logic [4:0]         mod_sum;
  card_kind_e         kind;
  logic               ok;

  // Weight the digit: double at even positions from the right
  assign dbl      = {digit_i, 1'b0};
  assign weighted = idx_i[0] ? ((dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0]) : digit_i;
  assign mod_sum  = {1'b0, mod_q} + {1'b0, weighted};

  // Advance total, running remainder and count
  always_comb begin
    total_d = total_q;
    mod_d   = mod_q;
    count_d = count_q;
    priority if (ctrl_i.clear) begin
      total_d = '0;
      mod_d   = '0;
      count_d = '0;
    end else if (ctrl_i.step) begin
      total_d = total_q + TOTAL_W'(weighted);
      mod_d   = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
      if (digit_i != 4'd0) begin
        count_d = COUNT_W'(idx_i) + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    mod_q   <= mod_d;
    count_q <= count_d;
    if (ctrl_i.step && idx_i == DIG_IDX_W'(12)) d12_q <= digit_i;
    if (ctrl_i.step && idx_i == DIG_IDX_W'(13)) d13_q <= digit_i;
    if (ctrl_i.step && idx_i == DIG_IDX_W'(14)) d14_q <= digit_i;
    if (ctrl_i.step && idx_i == DIG_IDX_W'(15)) d15_q <= digit_i;
  end

  // Classify by checksum, length and leading digits
  assign ok = (mod_q == 4'd0);

  always_comb begin
    kind = KIND_INVALID;
    if (ok) begin
      if (count_q == COUNT_W'(16)) begin
        if (d15_q == 4'd4) begin
          kind = KIND_VISA;
        end else if (d15_q == 4'd5 && d14_q >= 4'd1 && d14_q <= 4'd5) begin
          kind = KIND_MASTERCARD;
        end
      end else if (count_q == COUNT_W'(15)) begin
        if (d14_q == 4'd3 && (d13_q == 4'd4 || d13_q == 4'd7)) begin
          kind = KIND_AMEX;
        end
      end else if (count_q == COUNT_W'(13)) begin
        if (d12_q == 4'd4) begin
          kind = KIND_VISA;
        end
      end
    end
  end

  assign result_o = '{kind: kind, ok: ok, count: count_q, total: total_q};

endmodule

`default_nettype wire

FILE: hdl/luhn_card_number_classifier_core.sv
// Luhn card number classifier, top level.
// Each accepted item is converted by bit-serial double-dabble over its 63 input
// bits, its 19 BCD digits drain into the accumulator, then it finishes once the
// output register is free. A new item is taken only in idle, after that finish.
// A finished result waits in the output register while the next item runs.
// Reset: rst_ni clears the sequencer and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module luhn_card_number_classifier_core
  import luhn_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  luhn_in_if.sink    card_in_i,
  luhn_out_if.source result_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IN_W-1:0]   bin_q;
  logic              in_fire;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           acc_result;
  cell_ctrl_t        cell_ctrl;
  acc_ctrl_t         acc_ctrl;

  logic [3:0] cell_digit [MAX_DIGITS];
  logic       cell_carry [MAX_DIGITS+1];

  assign in_fire         = card_in_i.valid && card_in_i.ready;
  assign card_in_i.ready = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || result_o.ready;

  // Sequence one item: load, convert, drain, finish
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CONV;
          step_d  = '0;
        end
      end
      ST_CONV: begin
        if (step_q == STEP_W'(IN_W - 1)) begin
          state_d = ST_DRAIN;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (step_q == STEP_W'(MAX_DIGITS - 1)) begin
          state_d = ST_HOLD;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Hold the binary value and shift it out MSB first
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bin_q <= card_in_i.card_value;
    end else if (state_q == ST_CONV) begin
      bin_q <= {bin_q[IN_W-2:0], 1'b0};
    end
  end

  assign cell_ctrl = '{clear:   in_fire,
                       convert: (state_q == ST_CONV),
                       drain:   (state_q == ST_DRAIN)};
  assign acc_ctrl  = '{clear: in_fire, step: (state_q == ST_DRAIN)};

  // Chain of BCD digit cells, digit zero at the bottom
  assign cell_carry[0] = bin_q[IN_W-1];

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [3:0] upper_digit;
    if (i == MAX_DIGITS - 1) begin : g_top
      assign upper_digit = 4'd0;
    end else begin : g_mid
      assign upper_digit = cell_digit[i+1];
    end
    luhn_digit_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .bit_i   (cell_carry[i]),
      .digit_i (upper_digit),
      .bit_o   (cell_carry[i+1]),
      .digit_o (cell_digit[i])
    );
  end

  luhn_accum u_accum (
    .clk_i    (clk_i),
    .ctrl_i   (acc_ctrl),
    .digit_i  (cell_digit[0]),
    .idx_i    (step_q[DIG_IDX_W-1:0]),
    .result_o (acc_result)
  );

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_HOLD && out_free) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HOLD && out_free) begin
      out_q <= acc_result;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.card_kind   = out_q.kind;
  assign result_o.checksum_ok = out_q.ok;
  assign result_o.digit_count = out_q.count;
  assign result_o.luhn_total  = out_q.total;

`ifndef ASSERT_OFF
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_CONV && step_q == '0)
    else $error("accepted item did not start conversion");

  a_out_rise_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_HOLD)
    else $error("result valid rose outside the finish step");

  a_kind_needs_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != KIND_INVALID |-> out_q.ok)
    else $error("card kind set with failed checksum");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.count <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond chain length");

  a_drain_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> step_q <= STEP_W'(MAX_DIGITS - 1))
    else $error("drain step past last digit");
`endif

endmodule

`default_nettype wire
